/* hdl/i2cap_pkg.sv */
// Shared types and constants for the I2C address ACK probe.
package i2cap_pkg;

	// Field widths
	localparam int HalfW   = 10;
	localparam int LimitW  = 16;
	localparam int TimerW  = 16;
	localparam int AddrW   = 7;
	localparam int PaddrW  = 3;
	localparam int PdataW  = 32;
	localparam int InDataW  = 16;
	localparam int OutDataW = 8;

	// Reset values of the configuration registers
	localparam logic [HalfW-1:0]  HalfReset  = 10'd6;
	localparam logic [LimitW-1:0] LimitReset = 16'd1000;

	// Register index, taken from paddr[2]
	localparam logic REG_HALF  = 1'b0;
	localparam logic REG_LIMIT = 1'b1;

	// Sequencer phase codes
	localparam logic [3:0] PH_IDLE  = 4'd0;
	localparam logic [3:0] PH_PRE   = 4'd1;
	localparam logic [3:0] PH_STA1  = 4'd2;
	localparam logic [3:0] PH_STA2  = 4'd3;
	localparam logic [3:0] PH_BSET  = 4'd4;
	localparam logic [3:0] PH_BSTR  = 4'd5;
	localparam logic [3:0] PH_BHIGH = 4'd6;
	localparam logic [3:0] PH_BLOW  = 4'd7;
	localparam logic [3:0] PH_ASET  = 4'd8;
	localparam logic [3:0] PH_ASTR  = 4'd9;
	localparam logic [3:0] PH_AHIGH = 4'd10;
	localparam logic [3:0] PH_ALOW  = 4'd11;
	localparam logic [3:0] PH_P1    = 4'd12;
	localparam logic [3:0] PH_PSTR  = 4'd13;
	localparam logic [3:0] PH_PHIGH = 4'd14;
	localparam logic [3:0] PH_P2    = 4'd15;

	// Bits sent per frame (address plus write bit)
	localparam logic [3:0] BitsPerFrame = 4'd8;

	typedef struct packed {
		logic [HalfW-1:0]  half_period_ticks;
		logic [LimitW-1:0] stretch_limit_ticks;
	} cfg_t;

	typedef struct packed {
		logic             scl_level;
		logic             sda_level;
		logic [AddrW-1:0] target_address;
		logic             start_probe;
	} item_t;

	typedef struct packed {
		logic acked;
		logic probe_done;
		logic busy_res;
		logic scl_pull_low;
		logic sda_pull_low;
	} res_t;

endpackage

/* hdl/i2cap_regs.sv */
// APB configuration registers: half period and clock-stretch limit.
module i2cap_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [i2cap_pkg::PaddrW-1:0]  paddr,
	input  logic [i2cap_pkg::PdataW-1:0]  pwdata,
	output logic [i2cap_pkg::PdataW-1:0]  prdata,
	output logic                          pready,
	output i2cap_pkg::cfg_t               cfg
);
	import i2cap_pkg::*;

	logic [HalfW-1:0]  half_q;
	logic [LimitW-1:0] limit_q;
	logic              wr_en;
	logic              reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[2];

	// Write on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q  <= HalfReset;
			limit_q <= LimitReset;
		end else if (wr_en) begin
			case (reg_idx)
				REG_HALF:  half_q  <= pwdata[HalfW-1:0];
				REG_LIMIT: limit_q <= pwdata[LimitW-1:0];
				default:   half_q  <= half_q;
			endcase
		end
	end

	// Read back the selected register
	always_comb begin
		case (reg_idx)
			REG_HALF:  prdata = {{(PdataW-HalfW){1'b0}}, half_q};
			REG_LIMIT: prdata = {{(PdataW-LimitW){1'b0}}, limit_q};
			default:   prdata = '0;
		endcase
	end

	assign cfg.half_period_ticks   = half_q;
	assign cfg.stretch_limit_ticks = limit_q;

endmodule

/* hdl/i2cap_seq.sv */
// Line sequencer: one tick of the START / address / ACK / STOP state machine per beat.
module i2cap_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  i2cap_pkg::item_t item,
	input  i2cap_pkg::cfg_t  cfg,
	output i2cap_pkg::res_t  res
);
	import i2cap_pkg::*;

	logic [3:0]        phase_q, phase_d;
	logic [3:0]        bitcnt_q, bitcnt_d, bitcnt_inc;
	logic [7:0]        shift_q, shift_d;
	logic [TimerW-1:0] timer_q, timer_d, timer_dec, hold_val;
	logic              sda_q, sda_d;
	logic              scl_q, scl_d;
	logic              ack_q, ack_d;
	logic              done;
	logic              tmo;
	logic              str_over;
	logic [TimerW:0]   timer_inc;

	// Shared timer helpers
	assign tmo        = (timer_q <= 16'd1);
	assign timer_dec  = timer_q - 16'd1;
	assign timer_inc  = {1'b0, timer_q} + 17'd1;
	assign str_over   = item.scl_level || (timer_inc >= {1'b0, cfg.stretch_limit_ticks});
	assign hold_val   = {{(TimerW-HalfW){1'b0}}, cfg.half_period_ticks};
	assign bitcnt_inc = bitcnt_q + 4'd1;

	// Next state for one tick
	always_comb begin
		phase_d  = phase_q;
		bitcnt_d = bitcnt_q;
		shift_d  = shift_q;
		timer_d  = timer_q;
		sda_d    = sda_q;
		scl_d    = scl_q;
		ack_d    = ack_q;
		done     = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (item.start_probe) begin
					shift_d  = {item.target_address, 1'b0};
					bitcnt_d = '0;
					ack_d    = 1'b0;
					sda_d    = 1'b0;
					scl_d    = 1'b0;
					timer_d  = {{(TimerW-HalfW-1){1'b0}}, cfg.half_period_ticks, 1'b0};
					phase_d  = PH_PRE;
				end
			end
			PH_PRE, PH_STA1, PH_STA2, PH_BHIGH, PH_AHIGH, PH_ALOW, PH_PHIGH: begin
				if (!tmo) begin
					timer_d = timer_dec;
				end else begin
					timer_d = hold_val;
					case (phase_q)
						PH_PRE:   begin sda_d = 1'b1; phase_d = PH_STA1; end
						PH_STA1:  begin scl_d = 1'b1; phase_d = PH_STA2; end
						PH_STA2:  begin sda_d = !shift_q[7]; phase_d = PH_BSET; end
						PH_BHIGH: begin scl_d = 1'b1; phase_d = PH_BLOW; end
						PH_AHIGH: begin
							ack_d   = !item.sda_level;
							scl_d   = 1'b1;
							phase_d = PH_ALOW;
						end
						PH_ALOW:  begin sda_d = 1'b1; phase_d = PH_P1; end
						default:  begin sda_d = 1'b0; phase_d = PH_P2; end
					endcase
				end
			end
			PH_BSET, PH_ASET, PH_P1: begin
				if (!tmo) begin
					timer_d = timer_dec;
				end else begin
					scl_d   = 1'b0;
					timer_d = '0;
					case (phase_q)
						PH_BSET: phase_d = PH_BSTR;
						PH_ASET: phase_d = PH_ASTR;
						default: phase_d = PH_PSTR;
					endcase
				end
			end
			PH_BSTR, PH_ASTR, PH_PSTR: begin
				if (!str_over) begin
					timer_d = timer_inc[TimerW-1:0];
				end else begin
					timer_d = hold_val;
					case (phase_q)
						PH_BSTR: phase_d = PH_BHIGH;
						PH_ASTR: phase_d = PH_AHIGH;
						default: phase_d = PH_PHIGH;
					endcase
				end
			end
			PH_BLOW: begin
				if (!tmo) begin
					timer_d = timer_dec;
				end else begin
					shift_d  = {shift_q[6:0], 1'b0};
					bitcnt_d = bitcnt_inc;
					timer_d  = hold_val;
					if (bitcnt_inc >= BitsPerFrame) begin
						sda_d   = 1'b0;
						phase_d = PH_ASET;
					end else begin
						sda_d   = !shift_q[6];
						phase_d = PH_BSET;
					end
				end
			end
			PH_P2: begin
				if (!tmo) begin
					timer_d = timer_dec;
				end else begin
					sda_d   = 1'b0;
					scl_d   = 1'b0;
					timer_d = '0;
					phase_d = PH_IDLE;
					done    = 1'b1;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				sda_d   = 1'b0;
				scl_d   = 1'b0;
			end
		endcase
	end

	// Advance the state once per beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			bitcnt_q <= '0;
			shift_q  <= '0;
			timer_q  <= '0;
			sda_q    <= 1'b0;
			scl_q    <= 1'b0;
			ack_q    <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			bitcnt_q <= bitcnt_d;
			shift_q  <= shift_d;
			timer_q  <= timer_d;
			sda_q    <= sda_d;
			scl_q    <= scl_d;
			ack_q    <= ack_d;
		end
	end

	// Result reflects the state after this tick
	assign res.sda_pull_low = sda_d;
	assign res.scl_pull_low = scl_d;
	assign res.busy_res     = (phase_d != PH_IDLE);
	assign res.probe_done   = done;
	assign res.acked        = done && ack_d;

endmodule

/* hdl/i2c_address_ack_probe.sv */
// Top level of the I2C address ACK probe: stream ports, config port, pipeline.
//
// Usage: every input beat on s_axis is one timer tick. It carries the sampled
// SDA/SCL levels and, when idle, an optional start request with a 7-bit
// address. Each accepted beat yields exactly one result beat on m_axis with
// the open-drain line drives, busy, a one-beat done pulse and the ACK flag.
// The host turns sda_pull_low / scl_pull_low into pad enables.
// Path: a beat is taken into the input register, then the sequencer writes
// its result into the result register, which drives m_axis.
// Throughput: one beat per cycle while m_tready is high; the state machine
// and its timers update once per beat, so beats may arrive back to back.
// Stall: a waiting result holds while m_tready is low; an empty input
// register takes one more beat, then s_tready drops until m_tready rises.
// Reset: the sequencer returns to idle with both lines released, both stages
// empty, and the registers load half period 6 and stretch limit 1000.
// Configuration: APB, register 0 at 0x0 (half period), register 1 at 0x4
// (stretch limit); write only while no beats are in flight.
module i2c_address_ack_probe (
	input  logic                            clk,
	input  logic                            arst_n,
	// fields from bit 0: start_probe, target_address[7], sda_level, scl_level
	input  logic [i2cap_pkg::InDataW-1:0]   s_tdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// fields from bit 0: sda_pull_low, scl_pull_low, busy_res, probe_done, acked
	output logic [i2cap_pkg::OutDataW-1:0]  m_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [i2cap_pkg::PaddrW-1:0]    paddr,
	input  logic [i2cap_pkg::PdataW-1:0]    pwdata,
	output logic [i2cap_pkg::PdataW-1:0]    prdata,
	output logic                            pready
);
	import i2cap_pkg::*;

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	res_t  res;
	res_t  res_s2;
	logic  valid_s2;
	logic  adv_s1;

	i2cap_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Move stage 1 forward when the result register is free or drains
	assign adv_s1   = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= item_t'(s_tdata[$bits(item_t)-1:0]);
		end
	end

	i2cap_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (valid_s1 && adv_s1),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(OutDataW-$bits(res_t)){1'b0}}, res_s2};

endmodule

/* hdl/i2cap_checker.sv */
// Port-level checks for the I2C address ACK probe, bound to the top level.
module i2cap_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic [i2cap_pkg::OutDataW-1:0]  m_tdata,
	input logic                            m_tvalid,
	input logic                            m_tready
);
	import i2cap_pkg::*;

	// Result must hold while the receiver stalls
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed under stall");

	// ACK flag only rides on the done beat
	a_ack_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4] |-> m_tdata[3])
		else $error("acked without probe_done");

	// Done beat ends the run: not busy any more
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> !m_tdata[2])
		else $error("busy on done beat");

	// Done beat leaves both lines released
	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> !m_tdata[0] && !m_tdata[1])
		else $error("line still driven on done beat");

endmodule

bind i2c_address_ack_probe i2cap_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tdata  (m_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);
